// ===== rtl/fyts_pkg.sv =====
// Shared constants, payload types and command codes of the table shuffle block.
package fyts_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int WORD_BITS   = 64;
  localparam int RAND_W      = 31;
  localparam int DIV_W       = RAND_W + 1;
  localparam int SIZE_W      = 11;
  localparam int SWAPS_W     = 10;
  localparam int CFG_DATA_W  = 11;

  localparam logic [RAND_W-1:0] RANDOM_MAX = 31'h7FFF_FFFF;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_SWAP = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic REG_TABLE_SIZE = 1'b0;
  localparam logic REG_SWAP_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [WORD_BITS-1:0] word;
    logic [RAND_W-1:0]    random_word;
    logic [ADDR_W-1:0]    read_index;
  } fyts_in_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] read_word;
    logic                 status;
    logic                 shuffle_done;
  } fyts_out_t;

  typedef struct packed {
    logic              start;
    logic [RAND_W-1:0] dividend;
    logic [DIV_W-1:0]  divisor;
  } fyts_div_req_t;

  typedef struct packed {
    logic              done;
    logic [RAND_W-1:0] quotient;
  } fyts_div_rsp_t;

endpackage

// ===== rtl/fyts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fyts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/fyts_div.sv =====
// Restoring divider, one quotient bit per cycle.
module fyts_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fyts_pkg::fyts_div_req_t req,
  output fyts_pkg::fyts_div_rsp_t rsp
);
  import fyts_pkg::*;

  localparam int STEP_W = $clog2(RAND_W + 1);

  logic [DIV_W-1:0]  rem_r;
  logic [RAND_W-1:0] quo_r;
  logic [DIV_W-1:0]  dsr_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    trial;

  assign shifted = {rem_r, quo_r[RAND_W-1]};
  assign trial   = shifted - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dsr_r  <= req.divisor;
        cnt_r  <= STEP_W'(RAND_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // keep the difference when it does not borrow
        if (!trial[DIV_W]) begin
          rem_r <= trial[DIV_W-1:0];
        end else begin
          rem_r <= shifted[DIV_W-1:0];
        end
        quo_r <= {quo_r[RAND_W-2:0], ~trial[DIV_W]};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== rtl/fisher_yates_table_shuffle.sv =====
// Top level of the Fisher-Yates table shuffle block.
//
// A table of up to 1024 64-bit entries lives in one RAM. Load words fill it
// from entry 0, read words return one entry, and each swap word performs one
// Fisher-Yates step with the random value it carries. Every input word gives
// exactly one result word. A load, a refused command or an unknown command
// registers its result at the accepting edge. A read registers it at the
// next edge, from state S_READ, and the input stays stalled meanwhile. A swap
// registers its result after the states S_DIV1, S_DIV2, S_RDJ and S_WRJ. The
// shared one-bit-per-cycle divider runs twice per swap, and each run yields 31
// quotient bits. Then the partner entry j is read, and in S_RDJ it is written
// to entry i. Entry j is written at the edge that registers the result. The
// next word can be taken in the cycle that shows a result, and a result held
// by out_stall also holds the input. One input word is in work at a time.
// The table RAM has no reset; reading an entry that was never loaded is refused.
module fisher_yates_table_shuffle (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fyts_pkg::fyts_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fyts_pkg::fyts_out_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [fyts_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fyts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIV1,
    S_DIV2,
    S_RDJ,
    S_WRJ
  } state_t;

  state_t               state_r, state_nxt;
  logic [SIZE_W-1:0]    table_size_r;
  logic [SWAPS_W-1:0]   swap_count_r;
  logic [CNT_W-1:0]     load_r, load_nxt;
  logic [ADDR_W-1:0]    swap_r, swap_nxt;
  logic [RAND_W-1:0]    rand_r, rand_nxt;
  logic [WORD_BITS-1:0] data_i_r, data_i_nxt;
  logic [ADDR_W-1:0]    j_r, j_nxt;
  logic                 out_valid_r;
  fyts_out_t            out_data_r;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  fyts_div_req_t        div_req;
  fyts_div_rsp_t        div_rsp;

  logic                 in_acc;
  logic [CNT_W-1:0]     size_eff;
  logic [CNT_W-1:0]     swaps_eff;
  logic [CNT_W-1:0]     span;
  logic [DIV_W-1:0]     j_wide;
  logic [DIV_W-1:0]     j_lim;
  logic                 fin;
  logic                 fin_status;
  logic [WORD_BITS-1:0] fin_word;
  logic                 done_nxt;

  fyts_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fyts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // effective limits from the registers
  always_comb begin
    if (32'(table_size_r) > MAX_ENTRIES) begin
      size_eff = CNT_W'(MAX_ENTRIES);
    end else begin
      size_eff = CNT_W'(table_size_r);
    end
    if (size_eff == '0) begin
      swaps_eff = '0;
    end else if (CNT_W'(swap_count_r) > size_eff - 1'b1) begin
      swaps_eff = size_eff - 1'b1;
    end else begin
      swaps_eff = CNT_W'(swap_count_r);
    end
  end

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign span      = size_eff - CNT_W'(swap_r);
  assign j_wide    = DIV_W'(swap_r) + DIV_W'(div_rsp.quotient);
  assign j_lim     = DIV_W'(size_eff - 1'b1);

  always_comb begin
    state_nxt  = state_r;
    load_nxt   = load_r;
    swap_nxt   = swap_r;
    rand_nxt   = rand_r;
    data_i_nxt = data_i_r;
    j_nxt      = j_r;
    ram_we     = 1'b0;
    ram_waddr  = swap_r;
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = swap_r;
    div_req    = '0;
    fin        = 1'b0;
    fin_status = 1'b1;
    fin_word   = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.cmd)
            CMD_LOAD: begin
              fin = 1'b1;
              if (load_r < size_eff) begin
                ram_we     = 1'b1;
                ram_waddr  = load_r[ADDR_W-1:0];
                ram_wdata  = in_data.word;
                load_nxt   = load_r + 1'b1;
                fin_status = 1'b0;
              end
            end
            CMD_SWAP: begin
              if (load_r >= size_eff && CNT_W'(swap_r) < swaps_eff) begin
                // fetch entry i while the first division runs
                ram_re           = 1'b1;
                ram_raddr        = swap_r;
                div_req.start    = 1'b1;
                div_req.dividend = RANDOM_MAX;
                div_req.divisor  = DIV_W'(span);
                rand_nxt         = in_data.random_word;
                state_nxt        = S_DIV1;
              end else begin
                fin = 1'b1;
              end
            end
            CMD_READ: begin
              if (CNT_W'(in_data.read_index) < load_r &&
                  CNT_W'(in_data.read_index) < size_eff) begin
                ram_re    = 1'b1;
                ram_raddr = in_data.read_index;
                state_nxt = S_READ;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        fin        = 1'b1;
        fin_status = 1'b0;
        fin_word   = ram_rdata;
        state_nxt  = S_IDLE;
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = rand_r;
          div_req.divisor  = {1'b0, div_rsp.quotient} + 1'b1;
          data_i_nxt       = ram_rdata;
          state_nxt        = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          // saturate j to the last entry in use
          if (j_wide > j_lim) begin
            j_nxt = j_lim[ADDR_W-1:0];
          end else begin
            j_nxt = j_wide[ADDR_W-1:0];
          end
          ram_re    = 1'b1;
          ram_raddr = j_nxt;
          state_nxt = S_RDJ;
        end
      end
      S_RDJ: begin
        ram_we    = 1'b1;
        ram_waddr = swap_r;
        ram_wdata = ram_rdata;
        state_nxt = S_WRJ;
      end
      S_WRJ: begin
        ram_we     = 1'b1;
        ram_waddr  = j_r;
        ram_wdata  = data_i_r;
        swap_nxt   = swap_r + 1'b1;
        fin        = 1'b1;
        fin_status = 1'b0;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign done_nxt = (load_nxt >= size_eff) && (CNT_W'(swap_nxt) >= swaps_eff);

  always_ff @(posedge clk) begin
    rand_r   <= rand_nxt;
    data_i_r <= data_i_nxt;
    j_r      <= j_nxt;
    if (fin) begin
      out_data_r.read_word    <= fin_word;
      out_data_r.status       <= fin_status;
      out_data_r.shuffle_done <= done_nxt;
    end
    if (!rst_n) begin
      state_r      <= S_IDLE;
      table_size_r <= SIZE_W'(1024);
      swap_count_r <= SWAPS_W'(1023);
      load_r       <= '0;
      swap_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      load_r  <= load_nxt;
      swap_r  <= swap_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TABLE_SIZE: table_size_r <= cfg_data[SIZE_W-1:0];
          REG_SWAP_COUNT: swap_count_r <= cfg_data[SWAPS_W-1:0];
          default: ;
        endcase
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
